/* rtl/psd_pkg.sv */
package psd_pkg;

	typedef enum logic [1:0] {
		CASE_DEGEN    = 2'd0,
		CASE_START    = 2'd1,
		CASE_END      = 2'd2,
		CASE_INTERIOR = 2'd3
	} psd_case_t;

endpackage

/* rtl/psd_front.sv */
module psd_front import psd_pkg::*; #(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS = 8,
	parameter int SW = 86
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic signed [COORD_BITS-1:0] px,
	input  logic signed [COORD_BITS-1:0] py,
	input  logic signed [COORD_BITS-1:0] ax,
	input  logic signed [COORD_BITS-1:0] ay,
	input  logic signed [COORD_BITS-1:0] bx,
	input  logic signed [COORD_BITS-1:0] by,
	output logic                         out_valid,
	output psd_case_t                    out_code,
	output logic [SW-1:0]                out_num,
	output logic [SW-1:0]                out_den
);

	localparam int D = COORD_BITS + 1;
	localparam int P = 2 * D;
	localparam int MW = 2 * D + 1;
	localparam int H = (MW + 1) / 2;
	localparam int HW = MW - H;

	logic                valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic                degen_s1, degen_s2, degen_s3;
	logic signed [D-1:0] abx_s1, aby_s1, apx_s1, apy_s1, bpx_s1, bpy_s1;

	logic signed [P-1:0] d1a_s2, d1b_s2, d2a_s2, d2b_s2, cra_s2, crb_s2;
	logic signed [P-1:0] apxx_s2, apyy_s2, bpxx_s2, bpyy_s2, abxx_s2, abyy_s2;

	logic signed [P:0]   dot1_s3, dot2_s3, cross_s3, ap2_s3, bp2_s3, len2_s3;

	psd_case_t           code_s4, code_s5, code_s6;
	logic [MW-1:0]       mc_s4;
	logic [MW-1:0]       vsq_s4, vsq_s5;
	logic [MW-1:0]       den_s4, den_s5;

	logic [2*HW-1:0]     hh_s5;
	logic [HW+H-1:0]     hl_s5;
	logic [2*H-1:0]      ll_s5;

	logic [SW-1:0]       num_s6, den_s6;

	psd_case_t           code_c;
	logic [MW-1:0]       mc_c;
	logic [SW-1:0]       num_c;

	always_comb begin
		if (degen_s3) begin
			code_c = CASE_DEGEN;
		end else if (dot1_s3[P]) begin
			code_c = CASE_START;
		end else if (!dot2_s3[P] && dot2_s3 != '0) begin
			code_c = CASE_END;
		end else begin
			code_c = CASE_INTERIOR;
		end
		mc_c = cross_s3[P] ? MW'(-cross_s3) : MW'(cross_s3);
	end

	always_comb begin
		if (code_s5 == CASE_INTERIOR) begin
			num_c = (SW'(hh_s5) << (2 * H)) + (SW'(hl_s5) << (H + 1)) + SW'(ll_s5);
		end else begin
			num_c = SW'(vsq_s5);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		degen_s1 <= (ax == bx) && (ay == by);
		abx_s1   <= D'(bx) - D'(ax);
		aby_s1   <= D'(by) - D'(ay);
		apx_s1   <= D'(px) - D'(ax);
		apy_s1   <= D'(py) - D'(ay);
		bpx_s1   <= D'(px) - D'(bx);
		bpy_s1   <= D'(py) - D'(by);

		degen_s2 <= degen_s1;
		d1a_s2   <= abx_s1 * apx_s1;
		d1b_s2   <= aby_s1 * apy_s1;
		d2a_s2   <= abx_s1 * bpx_s1;
		d2b_s2   <= aby_s1 * bpy_s1;
		cra_s2   <= abx_s1 * apy_s1;
		crb_s2   <= aby_s1 * apx_s1;
		apxx_s2  <= apx_s1 * apx_s1;
		apyy_s2  <= apy_s1 * apy_s1;
		bpxx_s2  <= bpx_s1 * bpx_s1;
		bpyy_s2  <= bpy_s1 * bpy_s1;
		abxx_s2  <= abx_s1 * abx_s1;
		abyy_s2  <= aby_s1 * aby_s1;

		degen_s3 <= degen_s2;
		dot1_s3  <= (P+1)'(d1a_s2) + (P+1)'(d1b_s2);
		dot2_s3  <= (P+1)'(d2a_s2) + (P+1)'(d2b_s2);
		cross_s3 <= (P+1)'(cra_s2) - (P+1)'(crb_s2);
		ap2_s3   <= (P+1)'(apxx_s2) + (P+1)'(apyy_s2);
		bp2_s3   <= (P+1)'(bpxx_s2) + (P+1)'(bpyy_s2);
		len2_s3  <= (P+1)'(abxx_s2) + (P+1)'(abyy_s2);

		code_s4  <= code_c;
		mc_s4    <= mc_c;
		vsq_s4   <= (code_c == CASE_END) ? MW'(bp2_s3) : MW'(ap2_s3);
		den_s4   <= (code_c == CASE_INTERIOR) ? MW'(len2_s3) : MW'(1);

		code_s5  <= code_s4;
		vsq_s5   <= vsq_s4;
		den_s5   <= den_s4;
		hh_s5    <= mc_s4[MW-1:H] * mc_s4[MW-1:H];
		hl_s5    <= mc_s4[MW-1:H] * mc_s4[H-1:0];
		ll_s5    <= mc_s4[H-1:0] * mc_s4[H-1:0];

		code_s6  <= code_s5;
		num_s6   <= num_c << (2 * FRAC_BITS);
		den_s6   <= SW'(den_s5);
	end

	assign out_valid = valid_s6;
	assign out_code  = code_s6;
	assign out_num   = num_s6;
	assign out_den   = den_s6;

endmodule

/* rtl/psd_root_step.sv */
module psd_root_step import psd_pkg::*; #(
	parameter int SW = 86,
	parameter int DB = 25,
	parameter int K = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  psd_case_t     in_code,
	input  logic [SW-1:0] in_num,
	input  logic [SW-1:0] in_den,
	input  logic [SW-1:0] in_sq,
	input  logic [SW-1:0] in_rd,
	input  logic [DB-1:0] in_r,
	output logic          out_valid,
	output psd_case_t     out_code,
	output logic [SW-1:0] out_num,
	output logic [SW-1:0] out_den,
	output logic [SW-1:0] out_sq,
	output logic [SW-1:0] out_rd,
	output logic [DB-1:0] out_r
);

	logic          valid_s1;
	psd_case_t     code_s1;
	logic [SW-1:0] num_s1, den_s1, sq_s1, rd_s1;
	logic [DB-1:0] r_s1;
	logic [SW-1:0] cand;
	logic          take;

	// Trying bit K: (r + 2^K)^2 * den = sq + r*den*2^(K+1) + den*4^K.
	assign cand = in_sq + (in_rd << (K + 1)) + (in_den << (2 * K));
	assign take = cand <= in_num;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		code_s1 <= in_code;
		num_s1  <= in_num;
		den_s1  <= in_den;
		sq_s1   <= take ? cand : in_sq;
		rd_s1   <= take ? in_rd + (in_den << K) : in_rd;
		r_s1    <= take ? in_r | (DB'(1) << K) : in_r;
	end

	assign out_valid = valid_s1;
	assign out_code  = code_s1;
	assign out_num   = num_s1;
	assign out_den   = den_s1;
	assign out_sq    = sq_s1;
	assign out_rd    = rd_s1;
	assign out_r     = r_s1;

endmodule

/* rtl/point_segment_distance.sv */
// Throughput: one beat per cycle; busy is always low.
// Six front stages form differences, products and the case; one stage per
// result bit then runs a shift-and-add square root compare.
// Reset (arst_n low, asynchronous) clears all valid bits; done stays low.
module point_segment_distance import psd_pkg::*; #(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic signed [COORD_BITS-1:0]         point_x,
	input  logic signed [COORD_BITS-1:0]         point_y,
	input  logic signed [COORD_BITS-1:0]         seg_start_x,
	input  logic signed [COORD_BITS-1:0]         seg_start_y,
	input  logic signed [COORD_BITS-1:0]         seg_end_x,
	input  logic signed [COORD_BITS-1:0]         seg_end_y,
	output logic                                 done,
	output logic [COORD_BITS+FRAC_BITS:0]        distance,
	output logic [1:0]                           case_code
);

	localparam int DB = COORD_BITS + FRAC_BITS + 1;
	localparam int LW = 2 * (COORD_BITS + 1) + 1;
	localparam int SW = 2 * DB + LW + 1;

	logic          v_a   [DB+1];
	psd_case_t     c_a   [DB+1];
	logic [SW-1:0] num_a [DB+1];
	logic [SW-1:0] den_a [DB+1];
	logic [SW-1:0] sq_a  [DB+1];
	logic [SW-1:0] rd_a  [DB+1];
	logic [DB-1:0] r_a   [DB+1];

	assign busy = 1'b0;

	psd_front #(
		.COORD_BITS(COORD_BITS),
		.FRAC_BITS(FRAC_BITS),
		.SW(SW)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(start),
		.px(point_x),
		.py(point_y),
		.ax(seg_start_x),
		.ay(seg_start_y),
		.bx(seg_end_x),
		.by(seg_end_y),
		.out_valid(v_a[0]),
		.out_code(c_a[0]),
		.out_num(num_a[0]),
		.out_den(den_a[0])
	);

	assign sq_a[0] = '0;
	assign rd_a[0] = '0;
	assign r_a[0]  = '0;

	for (genvar i = 0; i < DB; i++) begin : g_root
		psd_root_step #(
			.SW(SW),
			.DB(DB),
			.K(DB - 1 - i)
		) u_step (
			.clk(clk),
			.arst_n(arst_n),
			.in_valid(v_a[i]),
			.in_code(c_a[i]),
			.in_num(num_a[i]),
			.in_den(den_a[i]),
			.in_sq(sq_a[i]),
			.in_rd(rd_a[i]),
			.in_r(r_a[i]),
			.out_valid(v_a[i+1]),
			.out_code(c_a[i+1]),
			.out_num(num_a[i+1]),
			.out_den(den_a[i+1]),
			.out_sq(sq_a[i+1]),
			.out_rd(rd_a[i+1]),
			.out_r(r_a[i+1])
		);
	end

	assign done      = v_a[DB];
	assign distance  = r_a[DB];
	assign case_code = c_a[DB];

endmodule
